// ----- hw/rtl/alu8_pkg.sv -----
// Package for the eight-bit ALU with status flags.
// Holds operation codes, status bit positions and the word types; no dependencies.
`default_nettype none

package alu8_pkg;

   localparam int DataWidth = 8;
   localparam int OpWidth   = 4;

   // Operation codes.
   localparam logic [OpWidth-1:0] OP_ORA     = 4'd0;
   localparam logic [OpWidth-1:0] OP_AND     = 4'd1;
   localparam logic [OpWidth-1:0] OP_EOR     = 4'd2;
   localparam logic [OpWidth-1:0] OP_ADC     = 4'd3;
   localparam logic [OpWidth-1:0] OP_SBC     = 4'd4;
   localparam logic [OpWidth-1:0] OP_CMP     = 4'd5;
   localparam logic [OpWidth-1:0] OP_BIT     = 4'd6;
   localparam logic [OpWidth-1:0] OP_ASL     = 4'd7;
   localparam logic [OpWidth-1:0] OP_LSR     = 4'd8;
   localparam logic [OpWidth-1:0] OP_ROL     = 4'd9;
   localparam logic [OpWidth-1:0] OP_ROR     = 4'd10;
   localparam logic [OpWidth-1:0] OP_INC     = 4'd11;
   localparam logic [OpWidth-1:0] OP_DEC     = 4'd12;
   localparam logic [OpWidth-1:0] OP_LOAD    = 4'd13;
   localparam logic [OpWidth-1:0] OP_CLRFLAG = 4'd14;
   localparam logic [OpWidth-1:0] OP_SETFLAG = 4'd15;

   // Status bit positions.
   localparam int FlagC = 0;
   localparam int FlagZ = 1;
   localparam int FlagV = 6;
   localparam int FlagN = 7;

   typedef struct packed {
      logic [OpWidth-1:0]   operation;
      logic [DataWidth-1:0] register_value;
      logic [DataWidth-1:0] operand;
      logic [DataWidth-1:0] status_in;
   } alu8_req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result_value;
      logic [DataWidth-1:0] status_out;
   } alu8_rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/alu8_core.sv -----
// Combinational datapath of the eight-bit ALU: result byte and new status byte.
// Depends on alu8_pkg.
`default_nettype none

module alu8_core
   import alu8_pkg::*;
(
   input  alu8_req_type req,
   output alu8_rsp_type rsp
);

   logic [DataWidth-1:0] a;
   logic [DataWidth-1:0] m;
   logic [DataWidth-1:0] st;
   logic                 cin;
   logic [DataWidth-1:0] addend;
   logic [DataWidth:0]   sum;
   logic [DataWidth:0]   diff;
   logic [DataWidth-1:0] r;
   logic [DataWidth-1:0] st_new;
   logic                 set_nz;

   assign a   = req.register_value;
   assign m   = req.operand;
   assign st  = req.status_in;
   assign cin = st[FlagC];

   // Subtract is an add of the inverted operand.
   assign addend = (req.operation == OP_SBC) ? ~m : m;
   assign sum    = {1'b0, a} + {1'b0, addend} + {{DataWidth{1'b0}}, cin};
   assign diff   = {1'b0, a} - {1'b0, m};

   always_comb begin
      r      = a;
      st_new = st;
      set_nz = 1'b1;
      case (req.operation)
         OP_ORA: r = a | m;
         OP_AND: r = a & m;
         OP_EOR: r = a ^ m;
         OP_ADC, OP_SBC: begin
            r             = sum[DataWidth-1:0];
            st_new[FlagC] = sum[DataWidth];
            st_new[FlagV] = ~(a[DataWidth-1] ^ addend[DataWidth-1])
                            & (a[DataWidth-1] ^ sum[DataWidth-1]);
         end
         OP_CMP: begin
            set_nz        = 1'b0;
            st_new[FlagC] = ~diff[DataWidth];
            st_new[FlagZ] = (a == m);
            st_new[FlagN] = diff[DataWidth-1];
         end
         OP_BIT: begin
            set_nz        = 1'b0;
            st_new[FlagZ] = ((a & m) == '0);
            st_new[FlagV] = m[FlagV];
            st_new[FlagN] = m[FlagN];
         end
         OP_ASL: begin
            r             = {m[DataWidth-2:0], 1'b0};
            st_new[FlagC] = m[DataWidth-1];
         end
         OP_LSR: begin
            r             = {1'b0, m[DataWidth-1:1]};
            st_new[FlagC] = m[0];
         end
         OP_ROL: begin
            r             = {m[DataWidth-2:0], cin};
            st_new[FlagC] = m[DataWidth-1];
         end
         OP_ROR: begin
            r             = {cin, m[DataWidth-1:1]};
            st_new[FlagC] = m[0];
         end
         OP_INC:  r = m + 8'd1;
         OP_DEC:  r = m - 8'd1;
         OP_LOAD: r = m;
         OP_CLRFLAG: begin
            set_nz = 1'b0;
            st_new = st & ~m;
         end
         OP_SETFLAG: begin
            set_nz = 1'b0;
            st_new = st | m;
         end
         default: begin
            set_nz = 1'b0;
         end
      endcase
      if (set_nz) begin
         st_new[FlagZ] = (r == '0);
         st_new[FlagN] = r[DataWidth-1];
      end
   end

   assign rsp.result_value = r;
   assign rsp.status_out   = st_new;

endmodule

`default_nettype wire

// ----- hw/rtl/eight_bit_alu_with_status_flags.sv -----
// Top level of the eight-bit ALU with a 6502-style status byte.
// Depends on alu8_pkg and alu8_core.
`default_nettype none

// Usage:
// Each request word carries an operation code, a register value, an operand
// byte and the current status byte on the req_ channel (valid/ready). Each
// request yields exactly one response word on the rsp_ channel carrying the
// new result byte and the updated status byte, in request order.
// The block is a two-stage pipeline. The request is captured in an input
// register; the ALU datapath then runs in a single pass of combinational
// logic into the result register that drives the rsp_ ports. The response
// word shows on rsp_valid once it has passed the input register and then
// the result register.
// Throughput is one word per cycle: both stages advance together whenever
// the result register is empty or its word is being taken in that cycle.
// When the receiver stalls, the response word holds steady and the input
// register still accepts one more word; only when both stages are full and
// rsp_ready is low does req_ready drop.
// A synchronous, active-high reset empties both stages. The block keeps no
// other state, so nothing else needs to be cleared.

module eight_bit_alu_with_status_flags
   import alu8_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [OpWidth-1:0]   req_operation,
   input  wire logic [DataWidth-1:0] req_register_value,
   input  wire logic [DataWidth-1:0] req_operand,
   input  wire logic [DataWidth-1:0] req_status_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [DataWidth-1:0]      rsp_result_value,
   output logic [DataWidth-1:0]      rsp_status_out
);

   logic         stage_valid_ff;
   logic         stage_valid_in;
   alu8_req_type stage_ff;
   alu8_req_type stage_in;
   logic         out_valid_ff;
   logic         out_valid_in;
   alu8_rsp_type out_ff;
   alu8_rsp_type out_in;
   alu8_rsp_type alu_rsp;
   logic         out_advance;
   logic         stage_advance;

   // The result register can load whenever it is empty or being drained.
   assign out_advance   = !out_valid_ff || rsp_ready;
   // The input register can load whenever it is empty or moving forward.
   assign stage_advance = !stage_valid_ff || out_advance;
   assign req_ready     = stage_advance;

   assign stage_in = '{operation:      req_operation,
                       register_value: req_register_value,
                       operand:        req_operand,
                       status_in:      req_status_in};

   alu8_core u_core (
      .req (stage_ff),
      .rsp (alu_rsp)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;
      if (out_advance) begin
         out_valid_in = stage_valid_ff;
         out_in       = alu_rsp;
      end
      if (stage_advance) begin
         stage_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (stage_advance) begin
         stage_ff <= stage_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_ff.result_value;
   assign rsp_status_out   = out_ff.status_out;

endmodule

`default_nettype wire

// ----- hw/rtl/alu8_checker.sv -----
// Port-level checker for the eight-bit ALU, bound to the top level.
// Depends on alu8_pkg.
`default_nettype none

module alu8_checker
   import alu8_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [DataWidth-1:0] rsp_result_value,
   input wire logic [DataWidth-1:0] rsp_status_out
);

   // A stalled response word holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
                                  && $stable(rsp_status_out))
      else $error("response word changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Backpressure only when the output is full and stalled.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a stalled response");

   // With no input accepted and a willing receiver while both stages empty out, the pipe drains.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && req_ready) && rsp_ready)
      ##1 (!(req_valid && req_ready) && rsp_ready) |=> !rsp_valid)
      else $error("response appeared without a request");

endmodule

bind eight_bit_alu_with_status_flags alu8_checker u_alu8_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_status_out   (rsp_status_out)
);

`default_nettype wire
